>>> rtl/vtp_pkg.sv
// ---------------------------------------------------------------------------
// vtp_pkg
// shared types and constants for the vertex transform and perspective divide
// ---------------------------------------------------------------------------
package vtp_pkg;

   localparam int QW         = 32;  // q16.16 word width
   localparam int FRAC_W     = 16;  // fraction bits
   localparam int NUM_REGS   = 8;   // 64-bit matrix registers
   localparam int REG_W      = 64;
   localparam int ADDR_W     = 6;   // byte address, 8 bytes a register
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CNT_W      = 3;   // holds 0..FIFO_DEPTH
   localparam int NUM_W      = QW + FRAC_W;  // dividend width
   localparam int DIV_STEPS  = NUM_W;        // one quotient bit a stage

   typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_type;

   // transformed point handed from front to back
   typedef struct packed {
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
      logic signed [QW-1:0] w;
      logic                 sat;
   } xform_type;

endpackage

>>> rtl/vtp_front.sv
// ---------------------------------------------------------------------------
// vtp_front
// matrix multiply: products, column sums, truncation and clamp
// ---------------------------------------------------------------------------
module vtp_front import vtp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  matrix_type           matrix,
   input  logic                 accept,
   input  logic signed [QW-1:0] in_x,
   input  logic signed [QW-1:0] in_y,
   input  logic signed [QW-1:0] in_z,
   input  logic [CNT_W-1:0]     fifo_count,
   output logic                 full,
   output logic                 push,
   output xform_type            push_item
);

   logic signed [QW-1:0]   m_ent [0:3][0:3];
   logic signed [QW-1:0]   pnt [0:2];
   logic signed [2*QW-1:0] prod_in [0:3][0:2];
   logic signed [2*QW-1:0] prod_ff [0:3][0:2];
   logic signed [QW-1:0]   trans_ff [0:3];
   logic                   vld1_ff;
   logic                   vld2_ff;
   xform_type              item_in;
   xform_type              item_ff;
   logic signed [QW-1:0]   col [0:3];
   logic [3:0]             col_sat;
   logic [CNT_W:0]         used;

   assign pnt[0] = in_x;
   assign pnt[1] = in_y;
   assign pnt[2] = in_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (c % 2 == 1) begin
               m_ent[r][c] = $signed(matrix[r*2 + c/2][REG_W-1:QW]);
            end else begin
               m_ent[r][c] = $signed(matrix[r*2 + c/2][QW-1:0]);
            end
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[c][i] = 64'(pnt[i]) * 64'(m_ent[i][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
         for (int c = 0; c < 4; c++) begin
            trans_ff[c] <= m_ent[3][c];
         end
      end
   end

   // exact q32.32 sum, floor to q16.16, clamp to 32 bits
   always_comb begin
      logic signed [2*QW+1:0] acc;
      logic signed [2*QW+1:0] sh;
      for (int c = 0; c < 4; c++) begin
         acc = 66'(prod_ff[c][0]) + 66'(prod_ff[c][1]) + 66'(prod_ff[c][2])
             + 66'($signed({trans_ff[c], 16'h0000}));
         sh = acc >>> FRAC_W;
         if (sh > 66'sh0_7FFF_FFFF) begin
            col[c]     = 32'sh7FFF_FFFF;
            col_sat[c] = 1'b1;
         end else if (sh < -66'sh0_8000_0000) begin
            col[c]     = -32'sh8000_0000;
            col_sat[c] = 1'b1;
         end else begin
            col[c]     = sh[QW-1:0];
            col_sat[c] = 1'b0;
         end
      end
      item_in.x   = col[0];
      item_in.y   = col[1];
      item_in.z   = col[2];
      item_in.w   = col[3];
      item_in.sat = |col_sat;
   end

   always_ff @(posedge clock) begin
      if (vld1_ff) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
      end
   end

   // credit: queue entries plus words still in flight here
   assign used      = {1'b0, fifo_count} + (CNT_W+1)'(vld1_ff) + (CNT_W+1)'(vld2_ff);
   assign full      = used >= (CNT_W+1)'(FIFO_DEPTH);
   assign push      = vld2_ff;
   assign push_item = item_ff;

endmodule

>>> rtl/vtp_fifo.sv
// ---------------------------------------------------------------------------
// vtp_fifo
// short queue between the transform front and the divide back
// ---------------------------------------------------------------------------
module vtp_fifo import vtp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xform_type        push_item,
   input  logic             pop,
   output logic             empty,
   output xform_type        head,
   output logic [CNT_W-1:0] count
);

   xform_type          mem_ff [0:FIFO_DEPTH-1];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];
   assign count = cnt_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue count past depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push lost");
`endif

endmodule

>>> rtl/vtp_back.sv
// ---------------------------------------------------------------------------
// vtp_back
// pipelined divide of x, y, z by w, clamp, and result register
// ---------------------------------------------------------------------------
module vtp_back import vtp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fifo_empty,
   input  xform_type            fifo_head,
   output logic                 fifo_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic signed [QW-1:0] out_x,
   output logic signed [QW-1:0] out_y,
   output logic signed [QW-1:0] out_z,
   output logic                 w_was_zero,
   output logic                 saturated
);

   typedef struct packed {
      logic [2:0][QW-1:0]    rem;
      logic [2:0][NUM_W-1:0] nq;   // dividend bits out, quotient bits in
      logic [2:0]            neg;
      logic [QW-1:0]         dvs;
      xform_type             item;
   } div_stage_type;

   div_stage_type      stg_ff [0:DIV_STEPS];
   logic               vld_ff [0:DIV_STEPS];
   div_stage_type      prep_in;
   logic               adv;
   logic               out_vld_ff;
   logic [QW-1:0]      res_in [0:2];
   logic               wz_in;
   logic               sat_in;
   logic [QW-1:0]      res_ff [0:2];
   logic               wz_ff;
   logic               sat_ff;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type n;
      logic [QW:0]   sh;
      n = s;
      for (int l = 0; l < 3; l++) begin
         sh = {s.rem[l], s.nq[l][NUM_W-1]};
         if (sh >= {1'b0, s.dvs}) begin
            n.rem[l] = QW'(sh - {1'b0, s.dvs});
            n.nq[l]  = {s.nq[l][NUM_W-2:0], 1'b1};
         end else begin
            n.rem[l] = sh[QW-1:0];
            n.nq[l]  = {s.nq[l][NUM_W-2:0], 1'b0};
         end
      end
      return n;
   endfunction

   // signs and magnitudes of the dividends and divisor
   always_comb begin
      logic [QW-1:0] v [0:2];
      v[0] = fifo_head.x;
      v[1] = fifo_head.y;
      v[2] = fifo_head.z;
      prep_in.item = fifo_head;
      prep_in.dvs  = fifo_head.w[QW-1] ? QW'(-fifo_head.w) : fifo_head.w;
      for (int l = 0; l < 3; l++) begin
         prep_in.rem[l] = '0;
         prep_in.neg[l] = v[l][QW-1] ^ fifo_head.w[QW-1];
         prep_in.nq[l]  = {(v[l][QW-1] ? QW'(-v[l]) : v[l]), {FRAC_W{1'b0}}};
      end
   end

   assign adv      = !out_vld_ff || rsp_pop;
   assign fifo_pop = adv && !fifo_empty;

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff[0] <= prep_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            stg_ff[k+1] <= div_step(stg_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !fifo_empty;
         for (int k = 0; k < DIV_STEPS; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         out_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   // sign fix and clamp of the quotients, pass-through when w is zero
   always_comb begin
      logic [QW-1:0]    raw [0:2];
      logic [NUM_W-1:0] q;
      logic [2:0]       qsat;
      div_stage_type    f;
      f      = stg_ff[DIV_STEPS];
      raw[0] = f.item.x;
      raw[1] = f.item.y;
      raw[2] = f.item.z;
      wz_in  = f.item.w == '0;
      for (int l = 0; l < 3; l++) begin
         q       = f.nq[l];
         qsat[l] = 1'b0;
         if (f.neg[l]) begin
            if (q > NUM_W'(48'h0000_8000_0000)) begin
               res_in[l] = 32'h8000_0000;
               qsat[l]   = 1'b1;
            end else begin
               res_in[l] = QW'(-q[QW-1:0]);
            end
         end else begin
            if (q > NUM_W'(48'h0000_7FFF_FFFF)) begin
               res_in[l] = 32'h7FFF_FFFF;
               qsat[l]   = 1'b1;
            end else begin
               res_in[l] = q[QW-1:0];
            end
         end
         if (wz_in) begin
            res_in[l] = raw[l];
         end
      end
      sat_in = f.item.sat || (!wz_in && (|qsat));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         wz_ff  <= wz_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_empty  = !out_vld_ff;
   assign out_x      = res_ff[0];
   assign out_y      = res_ff[1];
   assign out_z      = res_ff[2];
   assign w_was_zero = wz_ff;
   assign saturated  = sat_ff;

endmodule

>>> rtl/vertex_transform_perspective_divide_core.sv
// ---------------------------------------------------------------------------
// vertex_transform_perspective_divide_core
// q16.16 point times 4x4 matrix, then divide of x, y, z by w
// ---------------------------------------------------------------------------
//  channel   ports                          word
//  request   req_push / req_full            in_x, in_y, in_z
//  response  rsp_pop / rsp_empty            out_x/y/z, w_was_zero, saturated
//  csr       csr_psel/penable/pwrite, ...   eight 64-bit matrix registers at 8*i
//
//  one word in and one out per cycle when the response side keeps popping
//  pipeline: product and column-sum registers in the front, the queue, a divider
//  input register, 48 divider stages (one quotient bit each), 1 result register
//  reset is synchronous; the matrix comes out of reset as the identity
//  a stalled response freezes the divider; the front keeps taking words
//  until the 4-entry queue plus its own in-flight words are full
// ---------------------------------------------------------------------------
module vertex_transform_perspective_divide_core import vtp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request queue side
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [QW-1:0] req_in_x,
   input  logic signed [QW-1:0] req_in_y,
   input  logic signed [QW-1:0] req_in_z,
   // response queue side
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic signed [QW-1:0] rsp_out_x,
   output logic signed [QW-1:0] rsp_out_y,
   output logic signed [QW-1:0] rsp_out_z,
   output logic                 rsp_w_was_zero,
   output logic                 rsp_saturated,
   // csr port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_W-1:0]    csr_paddr,
   input  logic [REG_W-1:0]     csr_pwdata,
   output logic [REG_W-1:0]     csr_prdata,
   output logic                 csr_pready
);

   matrix_type       cfg_ff;
   logic             csr_wr;
   logic             accept;
   logic             front_push;
   xform_type        front_item;
   logic             fifo_pop;
   logic             fifo_empty;
   xform_type        fifo_head;
   logic [CNT_W-1:0] fifo_count;

   // csr write on the access phase, registers at 8-byte spacing
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = cfg_ff[csr_paddr[ADDR_W-1:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         // identity matrix
         cfg_ff[0] <= 64'h0000_0000_0001_0000;
         cfg_ff[1] <= 64'h0;
         cfg_ff[2] <= 64'h0001_0000_0000_0000;
         cfg_ff[3] <= 64'h0;
         cfg_ff[4] <= 64'h0;
         cfg_ff[5] <= 64'h0000_0000_0001_0000;
         cfg_ff[6] <= 64'h0;
         cfg_ff[7] <= 64'h0001_0000_0000_0000;
      end else if (csr_wr) begin
         cfg_ff[csr_paddr[ADDR_W-1:3]] <= csr_pwdata;
      end
   end

   assign accept = req_push && !req_full;

   // front: multiply, sum, clamp
   vtp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .matrix     (cfg_ff),
      .accept     (accept),
      .in_x       (req_in_x),
      .in_y       (req_in_y),
      .in_z       (req_in_z),
      .fifo_count (fifo_count),
      .full       (req_full),
      .push       (front_push),
      .push_item  (front_item)
   );

   // decoupling queue
   vtp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .head      (fifo_head),
      .count     (fifo_count)
   );

   // back: perspective divide and result register
   vtp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_head  (fifo_head),
      .fifo_pop   (fifo_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_z      (rsp_out_z),
      .w_was_zero (rsp_w_was_zero),
      .saturated  (rsp_saturated)
   );

endmodule
